// File: sv/suf_pkg.sv
// ----------------------------------------------------------------------------
// suf_pkg: shared types and constants for the set union filter
// Transaction structs, operation codes and the control word that moves
// down the chain of compare cells.
// ----------------------------------------------------------------------------
package suf_pkg;

  // default sizes, overridable at the top level
  localparam int unsigned DEF_TABLE_DEPTH = 64;
  localparam int unsigned DEF_VALUE_BITS  = 32;

  // width of fields fixed by the interface
  localparam int unsigned DATA_W = 32;
  localparam int unsigned POS_W  = 8;
  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

  // operation codes
  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_LOAD  = 2'd1,
    OP_CHECK = 2'd2
  } suf_op_e;

  // input transaction
  typedef struct packed {
    logic [1:0]               op;
    logic signed [DATA_W-1:0] value;
    logic                     last;
  } suf_in_t;

  // result transaction
  typedef struct packed {
    logic                     kept;
    logic signed [DATA_W-1:0] out_value;
    logic [POS_W-1:0]         position;
    logic                     overflow;
    logic                     done_res;
  } suf_out_t;

  // control word handed from cell to cell
  typedef struct packed {
    logic       valid;
    logic [1:0] op;
    logic       last;
    logic       overflow;
    logic       store;
    logic       hit;
  } suf_ctrl_t;

endpackage

// File: sv/set_union_filter.sv
// ----------------------------------------------------------------------------
// set_union_filter: union of two integer lists by membership check
// Input channel (in_valid_i / in_stall_o / in_i) takes one transaction per
// cycle while not stalled: op clear starts a job, op load stores a first-list
// value while the table has room and always keeps it, op check keeps a
// second-list value only if no stored entry of the current job matches. Every
// transaction gives exactly one result on the output channel (out_valid_o /
// out_stall_i / out_o) with the value, the keep flag, its union position
// (saturating at 255), the sticky overflow flag and the echoed last flag.
// The table is a row of TABLE_DEPTH cells; each transaction walks the row one
// cell per cycle unless the row is frozen, through every cell register and then
// the result register, and one transaction per cycle is sustained unless frozen.
// When the receiver stalls a waiting result, the whole row freezes and the
// input is stalled in the same cycle; nothing is lost or reordered.
// Reset empties the fill count, union count and overflow flag and clears
// the row of pending transactions; no clearing pass is needed, the table
// is usable in the first cycle after reset.
// ----------------------------------------------------------------------------
module set_union_filter #(
  parameter int unsigned TABLE_DEPTH = suf_pkg::DEF_TABLE_DEPTH,
  parameter int unsigned VALUE_BITS  = suf_pkg::DEF_VALUE_BITS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  suf_pkg::suf_in_t   in_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output suf_pkg::suf_out_t  out_o
);
  import suf_pkg::*;

  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  logic                     adv;
  suf_ctrl_t                ctrl_w   [TABLE_DEPTH+1];
  logic signed [DATA_W-1:0] value_w  [TABLE_DEPTH+1];
  logic [CNT_W-1:0]         limit_w  [TABLE_DEPTH+1];
  logic [IDX_W-1:0]         wr_idx_w [TABLE_DEPTH+1];

  // the row moves unless a finished result is held by the receiver
  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;

  // fill count and transaction tagging
  suf_head #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .CNT_W       (CNT_W),
    .IDX_W       (IDX_W)
  ) u_head (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .in_valid_i (in_valid_i),
    .in_i       (in_i),
    .ctrl_o     (ctrl_w[0]),
    .limit_o    (limit_w[0]),
    .wr_idx_o   (wr_idx_w[0])
  );

  assign value_w[0] = in_i.value;

  // row of table cells
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    suf_cell #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .VALUE_BITS  (VALUE_BITS),
      .CELL_IDX    (i),
      .CNT_W       (CNT_W),
      .IDX_W       (IDX_W)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .adv_i    (adv),
      .ctrl_i   (ctrl_w[i]),
      .value_i  (value_w[i]),
      .limit_i  (limit_w[i]),
      .wr_idx_i (wr_idx_w[i]),
      .ctrl_o   (ctrl_w[i+1]),
      .value_o  (value_w[i+1]),
      .limit_o  (limit_w[i+1]),
      .wr_idx_o (wr_idx_w[i+1])
    );
  end

  // keep decision, union position and result register
  suf_tail u_tail (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .ctrl_i      (ctrl_w[TABLE_DEPTH]),
    .value_i     (value_w[TABLE_DEPTH]),
    .out_valid_o (out_valid_o),
    .out_o       (out_o)
  );

endmodule

// File: sv/suf_head.sv
// ----------------------------------------------------------------------------
// suf_head: front end of the chain
// Keeps the fill count and overflow flag, decides where a load is stored
// and tags each accepted transaction before it enters the first cell.
// ----------------------------------------------------------------------------
module suf_head #(
  parameter int unsigned TABLE_DEPTH = suf_pkg::DEF_TABLE_DEPTH,
  parameter int unsigned CNT_W       = $clog2(TABLE_DEPTH + 1),
  parameter int unsigned IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 adv_i,
  input  logic                 in_valid_i,
  input  suf_pkg::suf_in_t     in_i,
  output suf_pkg::suf_ctrl_t   ctrl_o,
  output logic [CNT_W-1:0]     limit_o,
  output logic [IDX_W-1:0]     wr_idx_o
);
  import suf_pkg::*;

  logic [CNT_W-1:0] count_q, count_d;
  logic             ovf_q, ovf_d;
  logic             accept;
  logic             room;

  assign accept = in_valid_i && adv_i;
  assign room   = (count_q < CNT_W'(TABLE_DEPTH));

  // next fill count and overflow flag
  always_comb begin
    count_d = count_q;
    ovf_d   = ovf_q;
    case (in_i.op)
      OP_CLEAR: begin
        count_d = '0;
        ovf_d   = 1'b0;
      end
      OP_LOAD: begin
        if (room) begin
          count_d = count_q + CNT_W'(1);
        end else begin
          ovf_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else if (accept) begin
      count_q <= count_d;
      ovf_q   <= ovf_d;
    end
  end

  // tag the transaction for the chain
  always_comb begin
    ctrl_o.valid    = in_valid_i;
    ctrl_o.op       = in_i.op;
    ctrl_o.last     = in_i.last;
    ctrl_o.overflow = ovf_d;
    ctrl_o.store    = (in_i.op == OP_LOAD) && room;
    ctrl_o.hit      = 1'b0;
  end

  assign limit_o  = count_q;
  assign wr_idx_o = count_q[IDX_W-1:0];

  // fill count stays within the table
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(TABLE_DEPTH))
    else $error("fill count beyond table depth");

  // a clear empties the table and drops the overflow flag
  a_clear_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_i.op == OP_CLEAR) |=> (count_q == '0 && !ovf_q))
    else $error("clear did not reset fill state");

endmodule

// File: sv/suf_cell.sv
// ----------------------------------------------------------------------------
// suf_cell: one entry of the membership table
// Holds one stored value, takes a load addressed to it, compares passing
// checks against its entry and hands the transaction to the next cell.
// ----------------------------------------------------------------------------
module suf_cell #(
  parameter int unsigned TABLE_DEPTH = suf_pkg::DEF_TABLE_DEPTH,
  parameter int unsigned VALUE_BITS  = suf_pkg::DEF_VALUE_BITS,
  parameter int unsigned CELL_IDX    = 0,
  parameter int unsigned CNT_W       = $clog2(TABLE_DEPTH + 1),
  parameter int unsigned IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               adv_i,
  input  suf_pkg::suf_ctrl_t                 ctrl_i,
  input  logic signed [suf_pkg::DATA_W-1:0]  value_i,
  input  logic [CNT_W-1:0]                   limit_i,
  input  logic [IDX_W-1:0]                   wr_idx_i,
  output suf_pkg::suf_ctrl_t                 ctrl_o,
  output logic signed [suf_pkg::DATA_W-1:0]  value_o,
  output logic [CNT_W-1:0]                   limit_o,
  output logic [IDX_W-1:0]                   wr_idx_o
);
  import suf_pkg::*;

  logic [VALUE_BITS-1:0] entry_q;
  logic [VALUE_BITS-1:0] key;
  suf_ctrl_t             ctrl_q, ctrl_d;
  logic signed [DATA_W-1:0] value_q;
  logic [CNT_W-1:0]      limit_q;
  logic [IDX_W-1:0]      wr_idx_q;
  logic                  wr_en;
  logic                  match;

  // compare key is the low value bits, zero extended when wider
  if (VALUE_BITS <= DATA_W) begin : g_key_narrow
    assign key = value_i[VALUE_BITS-1:0];
  end else begin : g_key_wide
    assign key = {{(VALUE_BITS - DATA_W){1'b0}}, value_i};
  end

  assign wr_en = adv_i && ctrl_i.valid && ctrl_i.store && (wr_idx_i == IDX_W'(CELL_IDX));
  assign match = (ctrl_i.op == OP_CHECK) && (CNT_W'(CELL_IDX) < limit_i) && (key == entry_q);

  // stored entry
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      entry_q <= key;
    end
  end

  // fold this entry's match into the passing transaction
  always_comb begin
    ctrl_d     = ctrl_i;
    ctrl_d.hit = ctrl_i.hit | match;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else if (adv_i) begin
      ctrl_q <= ctrl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      value_q  <= value_i;
      limit_q  <= limit_i;
      wr_idx_q <= wr_idx_i;
    end
  end

  assign ctrl_o   = ctrl_q;
  assign value_o  = value_q;
  assign limit_o  = limit_q;
  assign wr_idx_o = wr_idx_q;

endmodule

// File: sv/suf_tail.sv
// ----------------------------------------------------------------------------
// suf_tail: end of the chain
// Decides whether each transaction is kept, hands out union positions in
// order and holds the result register toward the receiver.
// ----------------------------------------------------------------------------
module suf_tail (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               adv_i,
  input  suf_pkg::suf_ctrl_t                 ctrl_i,
  input  logic signed [suf_pkg::DATA_W-1:0]  value_i,
  output logic                               out_valid_o,
  output suf_pkg::suf_out_t                  out_o
);
  import suf_pkg::*;

  logic [POS_W-1:0] union_q, union_d;
  logic             kept;
  logic             out_valid_q;
  suf_out_t         out_q, out_d;

  // keep decision and next union count
  always_comb begin
    kept    = 1'b0;
    union_d = union_q;
    case (ctrl_i.op)
      OP_CLEAR: union_d = '0;
      OP_LOAD:  kept = 1'b1;
      OP_CHECK: kept = !ctrl_i.hit;
      default:  ;
    endcase
    if (kept && union_q != POS_MAX) begin
      union_d = union_q + POS_W'(1);
    end
  end

  always_comb begin
    out_d.kept      = kept;
    out_d.out_value = value_i;
    out_d.position  = kept ? union_q : '0;
    out_d.overflow  = ctrl_i.overflow;
    out_d.done_res  = ctrl_i.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      union_q     <= '0;
      out_valid_q <= 1'b0;
    end else if (adv_i) begin
      out_valid_q <= ctrl_i.valid;
      if (ctrl_i.valid) begin
        union_q <= union_d;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // a dropped value never carries a position
  a_pos_only_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.kept) |-> (out_q.position == '0))
    else $error("position set on a dropped value");

  // a clear leaving the chain restarts union numbering
  a_clear_union: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv_i && ctrl_i.valid && ctrl_i.op == OP_CLEAR) |=> (union_q == '0))
    else $error("union count not reset by clear");

endmodule

// File: tb/sv/tb_set_union_filter.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_set_union_filter: self-checking testbench for the set union filter
// A directed table covers the reset state, value extremes, every operation,
// the spare op code and jobs that run on past their last flag. Random jobs
// then fill the table past its depth, push the union position into
// saturation and mix hits, misses and noise. Each accepted transaction runs
// through a local membership predictor. Each result is compared field by
// field with the oldest expected one. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_set_union_filter;
  import suf_pkg::*;

  localparam int unsigned TBL_DEPTH   = DEF_TABLE_DEPTH;
  localparam int unsigned VAL_BITS    = DEF_VALUE_BITS;
  localparam int unsigned RAND_ITEMS  = 800;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned MAX_REPORTS = 10;
  localparam logic [DATA_W-1:0] VAL_MASK = {DATA_W{1'b1}} >> (DATA_W - VAL_BITS);
  // op code left unused by the block
  localparam logic [1:0] OP_SPARE = 2'd3;

  // expectation attached to one driven transaction
  typedef struct {
    bit       typed;
    suf_out_t want;
  } txn_tag_t;

  // one row of the directed table
  typedef struct {
    suf_in_t  stim;
    bit       typed;
    suf_out_t want;
  } dir_row_t;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_stall_o;
  suf_in_t  in_i        = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  suf_out_t out_o;

  // predictor state
  logic [DATA_W-1:0] member_mem [TBL_DEPTH];
  int unsigned       fill_cnt  = 0;
  int unsigned       union_cnt = 0;
  logic              ovf_seen  = 1'b0;

  txn_tag_t          accept_tag_q [$];
  suf_out_t          union_expect_q [$];
  dir_row_t          dir_rows [$];
  logic [DATA_W-1:0] prev_vals [$];
  int unsigned       err_cnt   = 0;
  int unsigned       sent_cnt  = 0;
  bit                in_calm   = 1'b0;
  int unsigned       stall_left = 0;
  int unsigned       calm_left  = 0;

  set_union_filter #(
    .TABLE_DEPTH(TBL_DEPTH),
    .VALUE_BITS (VAL_BITS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_i       (in_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_o      (out_o)
  );

  // clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // next union position, saturating at the top
  function automatic logic [POS_W-1:0] union_slot();
    logic [POS_W-1:0] pos;
    pos = union_cnt[POS_W-1:0];
    if (union_cnt < POS_MAX) union_cnt++;
    return pos;
  endfunction

  // membership predictor: updates local state, returns the expected result
  function automatic suf_out_t predict_union(suf_in_t txn);
    suf_out_t          res;
    logic [DATA_W-1:0] v;
    bit                hit;
    int unsigned       i;
    res           = '0;
    res.out_value = txn.value;
    res.done_res  = txn.last;
    v             = txn.value & VAL_MASK;
    case (txn.op)
      OP_CLEAR: begin
        fill_cnt  = 0;
        union_cnt = 0;
        ovf_seen  = 1'b0;
      end
      OP_LOAD: begin
        if (fill_cnt < TBL_DEPTH) begin
          member_mem[fill_cnt] = v;
          fill_cnt++;
        end else begin
          ovf_seen = 1'b1;
        end
        res.kept     = 1'b1;
        res.position = union_slot();
      end
      OP_CHECK: begin
        hit = 1'b0;
        for (i = 0; i < fill_cnt; i++) begin
          if (member_mem[i] == v) hit = 1'b1;
        end
        if (!hit) begin
          res.kept     = 1'b1;
          res.position = union_slot();
        end
      end
      default: ;
    endcase
    res.overflow = ovf_seen;
    return res;
  endfunction

  task automatic note_fail(input string msg);
    err_cnt++;
    if (err_cnt <= MAX_REPORTS) $display("[%0t] %s", $time, msg);
  endtask

  // idle gap ahead of the next transaction: mostly none or short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (in_calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // extremes and a few small values, to force matches and duplicates
  function automatic logic [DATA_W-1:0] pool_value();
    case ($urandom_range(0, 5))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom_range(1, 6);
    endcase
  endfunction

  // drive one transaction and hold it until accepted
  task automatic send_txn(input suf_in_t txn, input bit typed, input suf_out_t want);
    int unsigned gap;
    txn_tag_t    tag;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    tag.typed = typed;
    tag.want  = want;
    accept_tag_q.push_back(tag);
    in_valid_i <= 1'b1;
    in_i       <= txn;
    do @(posedge clk_i); while (in_stall_o);
    sent_cnt++;
  endtask

  task automatic add_row(input logic [1:0] op, input logic [DATA_W-1:0] value,
                         input logic last, input bit typed, input logic kept,
                         input logic [POS_W-1:0] pos, input logic ovf);
    dir_row_t row;
    row.stim.op         = op;
    row.stim.value      = value;
    row.stim.last       = last;
    row.typed           = typed;
    row.want.kept       = kept;
    row.want.out_value  = value;
    row.want.position   = pos;
    row.want.overflow   = ovf;
    row.want.done_res   = last;
    dir_rows.push_back(row);
  endtask

  // one job: optional clear, loads, then checks, with some noise mixed in
  task automatic run_job(input int unsigned n_load, input int unsigned n_check,
                         input bit with_clear, input int unsigned hit_pct);
    suf_in_t           job_q [$];
    suf_in_t           txn;
    logic [DATA_W-1:0] cur_vals [$];
    int unsigned       k;
    int unsigned       r;
    if (with_clear) begin
      txn.op    = OP_CLEAR;
      txn.value = $urandom;
      txn.last  = 1'b0;
      job_q.push_back(txn);
    end
    for (k = 0; k < n_load; k++) begin
      txn.op    = OP_LOAD;
      txn.value = ($urandom_range(0, 9) < 3) ? pool_value() : $urandom;
      txn.last  = 1'b0;
      cur_vals.push_back(txn.value);
      job_q.push_back(txn);
    end
    for (k = 0; k < n_check; k++) begin
      txn.op = OP_CHECK;
      r      = $urandom_range(0, 99);
      if (r < hit_pct && cur_vals.size() > 0)
        txn.value = cur_vals[$urandom_range(0, cur_vals.size() - 1)];
      else if (r < hit_pct + 10 && prev_vals.size() > 0)
        txn.value = prev_vals[$urandom_range(0, prev_vals.size() - 1)];
      else if (r < hit_pct + 20)
        txn.value = pool_value();
      else
        txn.value = $urandom;
      // occasional load after the checks have started
      if ($urandom_range(0, 19) == 0) begin
        txn.op = OP_LOAD;
        cur_vals.push_back(txn.value);
      end
      txn.last = 1'b0;
      job_q.push_back(txn);
    end
    // noise: spare op codes and early last flags
    for (k = 0; k < job_q.size(); k++) begin
      if ($urandom_range(0, 24) == 0) job_q[k].op = OP_SPARE;
      if ($urandom_range(0, 29) == 0) job_q[k].last = 1'b1;
    end
    if (job_q.size() > 0) job_q[job_q.size() - 1].last = 1'b1;
    in_calm = ($urandom_range(0, 3) == 0);
    for (k = 0; k < job_q.size(); k++) send_txn(job_q[k], 1'b0, '0);
    prev_vals = cur_vals;
  endtask

  // receiver stall: short bursts, a few long ones, and calm stretches
  always @(posedge clk_i) begin
    int unsigned r;
    if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= stall_left - 1;
    end else if (calm_left > 0) begin
      out_stall_i <= 1'b0;
      calm_left   <= calm_left - 1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 15) begin
        out_stall_i <= 1'b1;
        stall_left  <= $urandom_range(0, 2);
      end else if (r < 17) begin
        out_stall_i <= 1'b1;
        stall_left  <= $urandom_range(20, 60);
      end else if (r < 19) begin
        out_stall_i <= 1'b0;
        calm_left   <= $urandom_range(50, 200);
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // accepted input transaction: predict and queue the expected result
  always @(posedge clk_i) begin
    suf_out_t pred;
    txn_tag_t tag;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      pred = predict_union(in_i);
      if (accept_tag_q.size() == 0) begin
        note_fail("input transaction accepted that was never driven");
        union_expect_q.push_back(pred);
      end else begin
        tag = accept_tag_q.pop_front();
        union_expect_q.push_back(tag.typed ? tag.want : pred);
      end
    end
  end

  // accepted result: compare with the oldest expectation
  always @(posedge clk_i) begin
    suf_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (union_expect_q.size() == 0) begin
        note_fail($sformatf("unexpected result: kept=%0b value=%0d pos=%0d",
                            out_o.kept, out_o.out_value, out_o.position));
      end else begin
        want = union_expect_q.pop_front();
        if (out_o.kept != want.kept || out_o.out_value != want.out_value ||
            out_o.position != want.position || out_o.overflow != want.overflow ||
            out_o.done_res != want.done_res) begin
          note_fail($sformatf({"result mismatch: expected kept=%0b value=%0d pos=%0d ",
                               "ovf=%0b last=%0b, got kept=%0b value=%0d pos=%0d ",
                               "ovf=%0b last=%0b"},
                              want.kept, want.out_value, want.position,
                              want.overflow, want.done_res,
                              out_o.kept, out_o.out_value, out_o.position,
                              out_o.overflow, out_o.done_res));
        end
      end
    end
  end

  // cycle limit
  initial begin : watchdog
    int unsigned n;
    for (n = 0; n < CYCLE_LIMIT; n++) @(posedge clk_i);
    $display("== FAIL ==");
    $finish;
  end

  // stimulus
  initial begin : stimulus
    int unsigned k;
    int unsigned job_idx;
    int unsigned rand_start;
    bit          with_clear;
    // check before any clear sees an empty table
    add_row(OP_CHECK, 32'd5,        1'b0, 1'b1, 1'b1, 8'd0, 1'b0);
    add_row(OP_CLEAR, 32'h7fff_ffff, 1'b0, 1'b1, 1'b0, 8'd0, 1'b0);
    add_row(OP_LOAD,  32'h8000_0000, 1'b0, 1'b1, 1'b1, 8'd0, 1'b0);
    add_row(OP_LOAD,  32'h7fff_ffff, 1'b0, 1'b1, 1'b1, 8'd1, 1'b0);
    add_row(OP_LOAD,  32'h0000_0000, 1'b0, 1'b1, 1'b1, 8'd2, 1'b0);
    add_row(OP_LOAD,  32'hffff_ffff, 1'b0, 1'b1, 1'b1, 8'd3, 1'b0);
    // checks against the extremes just stored, and one miss
    add_row(OP_CHECK, 32'h8000_0000, 1'b0, 1'b1, 1'b0, 8'd0, 1'b0);
    add_row(OP_CHECK, 32'h7fff_ffff, 1'b0, 1'b1, 1'b0, 8'd0, 1'b0);
    add_row(OP_CHECK, 32'h0000_0001, 1'b0, 1'b0, 1'b0, 8'd0, 1'b0);
    add_row(OP_CHECK, 32'hffff_ffff, 1'b0, 1'b1, 1'b0, 8'd0, 1'b0);
    // duplicate load, near miss, spare op code
    add_row(OP_LOAD,  32'h8000_0000, 1'b0, 1'b0, 1'b0, 8'd0, 1'b0);
    add_row(OP_CHECK, 32'h8000_0001, 1'b0, 1'b0, 1'b0, 8'd0, 1'b0);
    add_row(OP_SPARE, 32'h5a5a_5a5a, 1'b0, 1'b1, 1'b0, 8'd0, 1'b0);
    add_row(OP_CHECK, 32'h0000_0000, 1'b1, 1'b0, 1'b0, 8'd0, 1'b0);
    // job continues past its last flag
    add_row(OP_LOAD,  32'd42,        1'b0, 1'b0, 1'b0, 8'd0, 1'b0);
    add_row(OP_CHECK, 32'd42,        1'b0, 1'b0, 1'b0, 8'd0, 1'b0);
    add_row(OP_CLEAR, 32'h8000_0000, 1'b1, 1'b1, 1'b0, 8'd0, 1'b0);
    // cleared table: repeated second-list values are all kept
    add_row(OP_CHECK, 32'd42,        1'b0, 1'b0, 1'b0, 8'd0, 1'b0);
    add_row(OP_CHECK, 32'd42,        1'b0, 1'b0, 1'b0, 8'd0, 1'b0);
    add_row(OP_CLEAR, 32'h0000_0000, 1'b0, 1'b1, 1'b0, 8'd0, 1'b0);
    add_row(OP_SPARE, 32'hffff_ffff, 1'b1, 1'b1, 1'b0, 8'd0, 1'b0);
    add_row(OP_CHECK, 32'h5555_5555, 1'b1, 1'b0, 1'b0, 8'd0, 1'b0);

    // reset
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (k = 0; k < dir_rows.size(); k++) begin
      send_txn(dir_rows[k].stim, dir_rows[k].typed, dir_rows[k].want);
    end

    // random jobs: first one overflows the table, second saturates position
    job_idx    = 0;
    rand_start = sent_cnt;
    while (sent_cnt - rand_start < RAND_ITEMS) begin
      if (job_idx == 0) begin
        run_job(TBL_DEPTH + 8, 16, 1'b1, 50);
      end else if (job_idx == 1) begin
        run_job(40, 320, 1'b1, 5);
      end else begin
        with_clear = ($urandom_range(0, 9) != 0);
        if ($urandom_range(0, 19) == 0)
          run_job($urandom_range(TBL_DEPTH - 4, TBL_DEPTH + 6),
                  $urandom_range(0, 14), with_clear, 40);
        else
          run_job($urandom_range(0, 12), $urandom_range(0, 14), with_clear, 40);
      end
      job_idx++;
    end
    in_valid_i <= 1'b0;

    // drain, then allow one more pass through the row of cells
    while (union_expect_q.size() != 0 || accept_tag_q.size() != 0) @(posedge clk_i);
    repeat (TBL_DEPTH + 16) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/suf_pkg.sv
sv/suf_head.sv
sv/suf_cell.sv
sv/suf_tail.sv
sv/set_union_filter.sv
tb/sv/tb_set_union_filter.sv
